// ===== rtl/multilevel_feedback_queue_scheduler_assert.svh =====
// Assertion macros for the feedback queue scheduler checker.
// Needs a clk and an active-low rst_n in the including scope.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define MFQS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfqs check failed");

// Next-cycle implication.
`define MFQS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfqs check failed");

`endif

// ===== rtl/mfqs_pkg.sv =====
// Types and constants shared by the feedback queue scheduler.
// No dependencies.
`default_nettype none
package mfqs_pkg;
    localparam int MAX_TASKS  = 64;
    localparam int NUM_LEVELS = 4;
    localparam int ID_W       = 6;
    localparam int LVL_W      = 2;
    localparam int TIME_W     = 16;
    localparam int CNT_W      = 7;
    localparam int QADDR_W    = LVL_W + ID_W;
    localparam int PERIOD_W   = 24;
    localparam int QUANT_W    = 10;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    localparam logic [1:0] CFG_BOOST_PERIOD = 2'd0;
    localparam logic [1:0] CFG_QUANTUM      = 2'd1;
    localparam logic [1:0] CFG_ALLOTMENT    = 2'd2;

    typedef enum logic [1:0] {
        MODE_TICK,
        MODE_SUBMIT,
        MODE_DISPATCH,
        MODE_REPORT
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISP_RD,
        ST_RPT_CALC,
        ST_RPT_WR,
        ST_BOOST_RD,
        ST_BOOST_WR
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] length;
        logic [TIME_W-1:0] ran;
        logic [TIME_W-1:0] used;
        logic [LVL_W-1:0]  level;
    } task_rec_t;

    typedef struct packed {
        logic            en;
        logic            level_only;
        logic [ID_W-1:0] addr;
        task_rec_t       rec;
    } task_wr_t;

    typedef struct packed {
        logic               en;
        logic [QADDR_W-1:0] addr;
        logic [ID_W-1:0]    data;
    } queue_wr_t;
endpackage
`default_nettype wire

// ===== rtl/mfqs_task_store.sv =====
// Per-task table memory: length, run time, allotment use and level.
// Depends on mfqs_pkg.
`default_nettype none
module mfqs_task_store (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [mfqs_pkg::ID_W-1:0]     rd_addr,
    output mfqs_pkg::task_rec_t           rd_data,
    input  mfqs_pkg::task_wr_t            wr
);
    import mfqs_pkg::*;

    logic [TIME_W-1:0] len_mem  [MAX_TASKS];
    logic [TIME_W-1:0] ran_mem  [MAX_TASKS];
    logic [TIME_W-1:0] used_mem [MAX_TASKS];
    logic [LVL_W-1:0]  lvl_mem  [MAX_TASKS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            lvl_mem[wr.addr] <= wr.rec.level;
            if (!wr.level_only)
            begin
                len_mem[wr.addr]  <= wr.rec.length;
                ran_mem[wr.addr]  <= wr.rec.ran;
                used_mem[wr.addr] <= wr.rec.used;
            end
        end
        if (rd_en)
        begin
            rd_data.length <= len_mem[rd_addr];
            rd_data.ran    <= ran_mem[rd_addr];
            rd_data.used   <= used_mem[rd_addr];
            rd_data.level  <= lvl_mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/mfqs_queue_store.sv =====
// Level queue memory: one ring of task ids per level.
// Depends on mfqs_pkg.
`default_nettype none
module mfqs_queue_store (
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic [mfqs_pkg::QADDR_W-1:0]   rd_addr,
    output logic [mfqs_pkg::ID_W-1:0]      rd_data,
    input  mfqs_pkg::queue_wr_t            wr
);
    import mfqs_pkg::*;

    logic [ID_W-1:0] q_mem [NUM_LEVELS*MAX_TASKS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            q_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data <= q_mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/multilevel_feedback_queue_scheduler.sv =====
// Four-level feedback queue scheduler: sequencer, queue pointers, registers.
// Depends on mfqs_pkg, mfqs_task_store and mfqs_queue_store.
//
// Input channel (in_valid/in_stall) takes one command per transaction:
// tick, submit, dispatch or run report. Output channel (out_valid/out_stall)
// returns exactly one result per command, in order. Configuration writes
// (cfg_valid/cfg_ready, always ready) set boost period, quantum and
// allotment; write them only while the block is idle.
// Ticks without boost, submits, empty dispatches and refused commands load
// the result register at acceptance; a dispatch first reads the queue head; a
// run report passes table read, clamp and write back; a boosting tick moves
// every task queued below the top level back to the top. in_stall stays high
// while a command is in flight and while a result waits in the output
// register, so one command is worked at a time.
// Reset empties all levels, deactivates all slots, zeroes the tick count and
// loads period 1000, quantum 50, allotment 200. A stalled result holds.
`default_nettype none
module multilevel_feedback_queue_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [5:0]  task_id,
    input  logic [15:0] task_length,
    input  logic [9:0]  run_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [5:0]  chosen_task,
    output logic [2:0]  chosen_level,
    output logic        task_done,
    output logic        boosted,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import mfqs_pkg::*;

    state_t state_reg, state_next;

    logic [PERIOD_W-1:0] period_reg;
    logic [QUANT_W-1:0]  quantum_reg;
    logic [TIME_W-1:0]   allot_reg;
    logic [PERIOD_W-1:0] tick_reg;
    logic [PERIOD_W-1:0] tick_next;
    logic                boost_hit;

    logic [MAX_TASKS-1:0] active_reg;
    logic [ID_W-1:0]      head_reg  [NUM_LEVELS];
    logic [CNT_W-1:0]     count_reg [NUM_LEVELS];

    logic [ID_W-1:0]   tid_reg;
    logic [QUANT_W-1:0] rtime_reg;
    logic [LVL_W-1:0]  lv_reg;
    task_rec_t         rec_reg;
    logic [TIME_W-1:0] rt_reg;

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [5:0]  chosen_task_reg;
    logic [2:0]  chosen_level_reg;
    logic        task_done_reg;
    logic        boosted_reg;

    logic            in_acc;
    mode_t           mode_in;
    logic            any_queued;
    logic [LVL_W-1:0] first_lv;

    logic               task_rd_en;
    logic [ID_W-1:0]    task_rd_addr;
    task_rec_t          task_rd_data;
    task_wr_t           task_wr;
    logic               q_rd_en;
    logic [QADDR_W-1:0] q_rd_addr;
    logic [ID_W-1:0]    q_rd_data;
    queue_wr_t          q_wr;

    logic             push_en;
    logic [LVL_W-1:0] push_lv;
    logic [ID_W-1:0]  push_id;
    logic             pop_en;
    logic [LVL_W-1:0] pop_lv;

    logic [TIME_W-1:0]  remain;
    logic [QUANT_W-1:0] rt_q;
    logic [TIME_W-1:0]  rt_calc;
    logic [TIME_W-1:0]  ran_new;
    logic [TIME_W:0]    used_sum;
    logic [TIME_W-1:0]  used_sat;
    logic               rpt_done;
    logic               demote;
    logic [LVL_W-1:0]   lv_out;
    logic [TIME_W-1:0]  used_out;
    logic               boost_last;

    mfqs_task_store u_task_store (
        .clk     (clk),
        .rd_en   (task_rd_en),
        .rd_addr (task_rd_addr),
        .rd_data (task_rd_data),
        .wr      (task_wr)
    );

    mfqs_queue_store u_queue_store (
        .clk     (clk),
        .rd_en   (q_rd_en),
        .rd_addr (q_rd_addr),
        .rd_data (q_rd_data),
        .wr      (q_wr)
    );

    assign mode_in   = mode_t'(mode);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign tick_next = tick_reg + 1'b1;
    assign boost_hit = tick_next >= period_reg;
    assign boost_last = lv_reg == LVL_W'(NUM_LEVELS - 1);

    always_comb
    begin
        any_queued = 1'b0;
        first_lv   = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                any_queued = 1'b1;
                first_lv   = LVL_W'(i);
            end
        end
    end

    // report arithmetic
    always_comb
    begin
        remain   = (task_rd_data.ran < task_rd_data.length) ?
                   task_rd_data.length - task_rd_data.ran : '0;
        rt_q     = (rtime_reg < quantum_reg) ? rtime_reg : quantum_reg;
        rt_calc  = ({{(TIME_W-QUANT_W){1'b0}}, rt_q} > remain) ?
                   remain : {{(TIME_W-QUANT_W){1'b0}}, rt_q};
        ran_new  = rec_reg.ran + rt_reg;
        used_sum = {1'b0, rec_reg.used} + {1'b0, rt_reg};
        used_sat = used_sum[TIME_W] ? '1 : used_sum[TIME_W-1:0];
        rpt_done = ran_new >= rec_reg.length;
        demote   = !rpt_done && (used_sat > allot_reg);
        lv_out   = (demote && rec_reg.level != LVL_W'(NUM_LEVELS - 1)) ?
                   rec_reg.level + 1'b1 : rec_reg.level;
        used_out = demote ? '0 : used_sat;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (mode_in)
                        MODE_TICK:     if (boost_hit) state_next = ST_BOOST_RD;
                        MODE_DISPATCH: if (any_queued) state_next = ST_DISP_RD;
                        MODE_REPORT:   if (active_reg[task_id]) state_next = ST_RPT_CALC;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DISP_RD:  state_next = ST_IDLE;
            ST_RPT_CALC: state_next = ST_RPT_WR;
            ST_RPT_WR:   state_next = ST_IDLE;
            ST_BOOST_RD:
            begin
                if (count_reg[lv_reg] != '0)
                    state_next = ST_BOOST_WR;
                else if (boost_last)
                    state_next = ST_IDLE;
            end
            ST_BOOST_WR: state_next = ST_BOOST_RD;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b1;
        task_rd_en   = 1'b0;
        task_rd_addr = task_id;
        task_wr      = '0;
        q_rd_en      = 1'b0;
        q_rd_addr    = '0;
        push_en      = 1'b0;
        push_lv      = '0;
        push_id      = '0;
        pop_en       = 1'b0;
        pop_lv       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = out_valid_reg;
                if (in_acc)
                begin
                    unique case (mode_in)
                        MODE_SUBMIT:
                        begin
                            if (!active_reg[task_id])
                            begin
                                task_wr.en         = 1'b1;
                                task_wr.addr       = task_id;
                                task_wr.rec.length = task_length;
                                push_en = count_reg[0] != CNT_W'(MAX_TASKS);
                                push_id = task_id;
                            end
                        end
                        MODE_DISPATCH:
                        begin
                            if (any_queued)
                            begin
                                q_rd_en   = 1'b1;
                                q_rd_addr = {first_lv, head_reg[first_lv]};
                                pop_en    = 1'b1;
                                pop_lv    = first_lv;
                            end
                        end
                        MODE_REPORT: task_rd_en = active_reg[task_id];
                        default: ;
                    endcase
                end
            end
            ST_RPT_WR:
            begin
                task_wr.en   = 1'b1;
                task_wr.addr = tid_reg;
                task_wr.rec  = '{length: rec_reg.length, ran: ran_new,
                                 used: used_out, level: lv_out};
                push_en = !rpt_done && (count_reg[lv_out] != CNT_W'(MAX_TASKS));
                push_lv = lv_out;
                push_id = tid_reg;
            end
            ST_BOOST_RD:
            begin
                if (count_reg[lv_reg] != '0)
                begin
                    q_rd_en   = 1'b1;
                    q_rd_addr = {lv_reg, head_reg[lv_reg]};
                    pop_en    = 1'b1;
                    pop_lv    = lv_reg;
                end
            end
            ST_BOOST_WR:
            begin
                task_wr.en         = 1'b1;
                task_wr.level_only = 1'b1;
                task_wr.addr       = q_rd_data;
                push_en = count_reg[0] != CNT_W'(MAX_TASKS);
                push_id = q_rd_data;
            end
            default: ;
        endcase
        q_wr.en   = push_en;
        q_wr.addr = {push_lv, head_reg[push_lv] + count_reg[push_lv][ID_W-1:0]};
        q_wr.data = push_id;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            period_reg  <= PERIOD_W'(1000);
            quantum_reg <= QUANT_W'(50);
            allot_reg   <= TIME_W'(200);
            tick_reg    <= '0;
            active_reg  <= '0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_BOOST_PERIOD: period_reg  <= cfg_data;
                    CFG_QUANTUM:      quantum_reg <= cfg_data[QUANT_W-1:0];
                    CFG_ALLOTMENT:    allot_reg   <= cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (pop_en)
            begin
                head_reg[pop_lv]  <= head_reg[pop_lv] + 1'b1;
                count_reg[pop_lv] <= count_reg[pop_lv] - 1'b1;
            end
            if (push_en)
            begin
                count_reg[push_lv] <= count_reg[push_lv] + 1'b1;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (mode_in == MODE_TICK)
                            tick_reg <= boost_hit ? '0 : tick_next;
                        if (mode_in == MODE_SUBMIT && !active_reg[task_id])
                            active_reg[task_id] <= 1'b1;
                        out_valid_reg <= !((mode_in == MODE_TICK && boost_hit) ||
                                           (mode_in == MODE_DISPATCH && any_queued) ||
                                           (mode_in == MODE_REPORT && active_reg[task_id]));
                    end
                end
                ST_DISP_RD:  out_valid_reg <= 1'b1;
                ST_RPT_WR:
                begin
                    out_valid_reg <= 1'b1;
                    if (rpt_done)
                        active_reg[tid_reg] <= 1'b0;
                end
                ST_BOOST_RD:
                begin
                    if (count_reg[lv_reg] == '0 && boost_last)
                        out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    tid_reg          <= task_id;
                    rtime_reg        <= run_time;
                    lv_reg           <= (mode_in == MODE_TICK) ? LVL_W'(1) : first_lv;
                    status_reg       <= STATUS_OK;
                    chosen_task_reg  <= '0;
                    chosen_level_reg <= '0;
                    task_done_reg    <= 1'b0;
                    boosted_reg      <= 1'b0;
                    case (mode_in)
                        MODE_SUBMIT:
                        begin
                            chosen_task_reg <= task_id;
                            if (active_reg[task_id])
                                status_reg <= STATUS_BAD;
                            else
                                chosen_level_reg <= 3'd1;
                        end
                        MODE_DISPATCH:
                            if (!any_queued) status_reg <= STATUS_EMPTY;
                        MODE_REPORT:
                        begin
                            chosen_task_reg <= task_id;
                            if (!active_reg[task_id]) status_reg <= STATUS_BAD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DISP_RD:
            begin
                chosen_task_reg  <= q_rd_data;
                chosen_level_reg <= {1'b0, lv_reg} + 3'd1;
            end
            ST_RPT_CALC:
            begin
                rec_reg <= task_rd_data;
                rt_reg  <= rt_calc;
            end
            ST_RPT_WR:
            begin
                chosen_level_reg <= {1'b0, lv_out} + 3'd1;
                task_done_reg    <= rpt_done;
            end
            ST_BOOST_RD:
            begin
                if (count_reg[lv_reg] == '0)
                begin
                    if (boost_last)
                        boosted_reg <= 1'b1;
                    else
                        lv_reg <= lv_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign chosen_task  = chosen_task_reg;
    assign chosen_level = chosen_level_reg;
    assign task_done    = task_done_reg;
    assign boosted      = boosted_reg;
endmodule
`default_nettype wire

// ===== rtl/mfqs_checker.sv =====
// Port-level checker for the feedback queue scheduler, bound to the top level.
// Depends on mfqs_pkg and multilevel_feedback_queue_scheduler_assert.svh.
`default_nettype none
`include "multilevel_feedback_queue_scheduler_assert.svh"
module mfqs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic [2:0] chosen_level,
    input logic       task_done,
    input logic       boosted
);
    import mfqs_pkg::*;

    `MFQS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `MFQS_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)
    `MFQS_ASSERT_NOW(a_refused_clean, out_valid && status == STATUS_BAD,
        chosen_level == 3'd0 && !task_done && !boosted)
    `MFQS_ASSERT_NOW(a_boost_clean, out_valid && boosted,
        status == STATUS_OK && chosen_level == 3'd0 && !task_done)
    `MFQS_ASSERT_NOW(a_level_range, out_valid, chosen_level <= 3'd4 && status <= STATUS_BAD)
endmodule

bind multilevel_feedback_queue_scheduler mfqs_checker u_mfqs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .chosen_level (chosen_level),
    .task_done    (task_done),
    .boosted      (boosted)
);
`default_nettype wire
